// ===== rtl/fqr_pkg.sv =====
package fqr_pkg;

  // Number of entries in the element store.
  localparam int unsigned DEPTH = 16;

  // Store address width and the width of a count that can hold DEPTH itself.
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Fixed field widths of the words on the two channels.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  // Width wide enough to compare a position against the fill count.
  localparam int unsigned CMP_W = (CNT_W > POS_W + 1) ? CNT_W : POS_W + 1;

  typedef enum logic [1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_REM = 2'd2,
    MODE_NOP = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    mode_t                     mode;
    logic signed [DATA_W-1:0]  value;
    logic        [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  front_value;
    logic signed [DATA_W-1:0]  back_value;
    logic        [COUNT_W-1:0] count;
    logic                      is_empty;
    status_t                   status;
  } rsp_t;

  // Physical slot of the element at a given offset from the front.
  function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] head,
                                             input logic [CNT_W-1:0]  offset);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(offset);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/fqr_ram.sv =====
module fqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/fifo_queue_with_remove_at_index.sv =====
// Bounded queue of signed 32-bit words held in a circular store of DEPTH entries, with
// enqueue at the back, dequeue at the front and removal at a position from the front.
// Every accepted request word returns one response word with the front and back values,
// the count, an empty flag and a status; a failed operation leaves the queue unchanged.
// One request is handled at a time. Enqueue, dequeue, no-op, failed operations and the
// removal of the back element go from the accept cycle through two reads of the single
// RAM read port, capture and output; output waits until the output register is free.
// A removal at position p below n - 1 with n elements held first moves the later
// elements forward, one element per cycle through the RAM's read and write ports. The
// next request is taken while the previous response still waits in the output register.
module fifo_queue_with_remove_at_index (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  fqr_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output fqr_pkg::rsp_t rsp
);

  import fqr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SHIFT    = 7'b0000010,
    S_DRAIN    = 7'b0000100,
    S_RD_FRONT = 7'b0001000,
    S_RD_BACK  = 7'b0010000,
    S_FIN      = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t                   state;
  logic [ADDR_W-1:0]        head;
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         idx;
  logic                     pend;
  logic [ADDR_W-1:0]        wa;
  status_t                  op_status;
  logic signed [DATA_W-1:0] front_q;
  logic signed [DATA_W-1:0] back_q;

  logic                     ram_wr_en;
  logic [ADDR_W-1:0]        ram_wr_addr;
  logic [DATA_W-1:0]        ram_wr_data;
  logic [ADDR_W-1:0]        ram_rd_addr;
  logic [DATA_W-1:0]        ram_rd_data;

  logic                     accept;
  logic                     is_full;
  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         pos_inc;
  logic [CMP_W-1:0]         cnt_ext;
  logic                     rsp_free;

  assign accept   = req_valid && req_ready;
  assign is_full  = (count == CNT_W'(DEPTH));
  assign pos_ext  = CMP_W'(req.position);
  assign pos_inc  = pos_ext + CMP_W'(1);
  assign cnt_ext  = CMP_W'(count);
  assign rsp_free = !rsp_valid || rsp_ready;

  assign req_ready = (state == S_IDLE);

  // Memory port selection: enqueue writes in the accept cycle, the shift writes
  // the word read in the previous cycle into the slot just ahead of it.
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = wa;
    ram_wr_data = ram_rd_data;
    ram_rd_addr = head;
    unique case (state)
      S_IDLE: begin
        ram_wr_en   = accept && (req.mode == MODE_ENQ) && !is_full;
        ram_wr_addr = slot(head, count);
        ram_wr_data = req.value;
      end
      S_SHIFT: begin
        ram_wr_en   = pend;
        ram_rd_addr = slot(head, idx);
      end
      S_DRAIN: begin
        ram_wr_en = 1'b1;
      end
      S_RD_BACK: begin
        ram_rd_addr = slot(head, count - CNT_W'(1));
      end
      S_RD_FRONT, S_FIN, S_EMIT: begin
        ram_rd_addr = head;
      end
      default: begin
        ram_rd_addr = head;
      end
    endcase
  end

  fqr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Sequencer: applies the operation, shifts after a removal, then reads back
  // the front and back entries and presents the response word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // A taken response word is dropped unless the next one replaces it.
      if (rsp_valid && rsp_ready && (state != S_EMIT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_status <= ST_OK;
            state     <= S_RD_FRONT;
            case (req.mode)
              MODE_ENQ: begin
                if (is_full) begin
                  op_status <= ST_FULL;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              MODE_DEQ: begin
                if (count == '0) begin
                  op_status <= ST_EMPTY;
                end else begin
                  head  <= slot(head, CNT_W'(1));
                  count <= count - CNT_W'(1);
                end
              end
              MODE_REM: begin
                if (count == '0) begin
                  op_status <= ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                  op_status <= ST_RANGE;
                end else if (pos_inc < cnt_ext) begin
                  idx   <= CNT_W'(pos_inc);
                  pend  <= 1'b0;
                  state <= S_SHIFT;
                end else begin
                  count <= count - CNT_W'(1);
                end
              end
              default: begin
                op_status <= ST_OK;
              end
            endcase
          end
        end
        S_SHIFT: begin
          pend <= 1'b1;
          wa   <= slot(head, idx - CNT_W'(1));
          idx  <= idx + CNT_W'(1);
          if (idx + CNT_W'(1) == count) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          pend  <= 1'b0;
          count <= count - CNT_W'(1);
          state <= S_RD_FRONT;
        end
        S_RD_FRONT: begin
          state <= S_RD_BACK;
        end
        S_RD_BACK: begin
          front_q <= (count != '0) ? ram_rd_data : '0;
          state   <= S_FIN;
        end
        S_FIN: begin
          back_q <= (count != '0) ? ram_rd_data : '0;
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (rsp_free) begin
            rsp_valid       <= 1'b1;
            rsp.front_value <= front_q;
            rsp.back_value  <= back_q;
            rsp.count       <= COUNT_W'(count);
            rsp.is_empty    <= (count == '0);
            rsp.status      <= op_status;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The fill count never goes past the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("fill count exceeds depth");

  // A full status is only reported when the queue really holds DEPTH words.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.count == COUNT_W'(DEPTH))
    else $error("full status with a partial queue");

  // An empty response carries zero values and a zero count.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_empty |->
      (rsp.front_value == '0) && (rsp.back_value == '0) && (rsp.count == '0))
    else $error("empty response with nonzero fields");

  // During the shift the write never lands on the slot being read.
  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) && ram_wr_en |-> ram_wr_addr != ram_rd_addr)
    else $error("shift write collides with read");
`endif

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import fqr_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned DRAIN_CYCLES    = 2 * (DEPTH + 4);
  localparam int unsigned WORDS_PER_PHASE = 450;
  localparam int unsigned HOLD_AFTER      = 150;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned MAX_REPORTS     = 10;

  localparam logic signed [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] LAST_FILL = 32'sh1234_5678;

  typedef struct {
    req_t word;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  // Shadow copy of the queue contents.
  logic signed [DATA_W-1:0] mirror_mem [DEPTH];
  logic [ADDR_W-1:0]        mirror_head = '0;
  logic [CNT_W-1:0]         mirror_cnt = '0;

  rsp_t        pending_rsp [$];
  dir_row_t    dir_tab [$];
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  int unsigned words_taken = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  logic        hold_rsp = 1'b0;

  fifo_queue_with_remove_at_index u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  // Physical slot of the element at a given offset from the shadow front.
  function automatic logic [ADDR_W-1:0] mirror_slot(input int unsigned offset);
    return ADDR_W'((mirror_head + offset) % DEPTH);
  endfunction

  // Apply one request word to the shadow queue and return the response it yields.
  function automatic rsp_t predict_queue_op(input req_t w);
    rsp_t        r;
    status_t     st;
    int unsigned i;
    st = ST_OK;
    case (w.mode)
      MODE_ENQ: begin
        if (mirror_cnt >= CNT_W'(DEPTH)) begin
          st = ST_FULL;
        end else begin
          mirror_mem[mirror_slot(mirror_cnt)] = w.value;
          mirror_cnt = mirror_cnt + 1'b1;
        end
      end
      MODE_DEQ: begin
        if (mirror_cnt == 0) begin
          st = ST_EMPTY;
        end else begin
          mirror_head = mirror_slot(1);
          mirror_cnt = mirror_cnt - 1'b1;
        end
      end
      MODE_REM: begin
        if (mirror_cnt == 0) begin
          st = ST_EMPTY;
        end else if (w.position >= mirror_cnt) begin
          st = ST_RANGE;
        end else begin
          // Close the gap by moving every later element one place forward.
          for (i = w.position; i + 1 < mirror_cnt; i++) begin
            mirror_mem[mirror_slot(i)] = mirror_mem[mirror_slot(i + 1)];
          end
          mirror_cnt = mirror_cnt - 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.front_value = '0;
    r.back_value  = '0;
    if (mirror_cnt != 0) begin
      r.front_value = mirror_mem[mirror_slot(0)];
      r.back_value  = mirror_mem[mirror_slot(mirror_cnt - 1)];
    end
    r.count    = COUNT_W'(mirror_cnt);
    r.is_empty = (mirror_cnt == 0);
    r.status   = st;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic signed [DATA_W-1:0] f,
                                  input logic signed [DATA_W-1:0] b,
                                  input logic [COUNT_W-1:0] c, input logic e,
                                  input status_t s);
    rsp_t r;
    r.front_value = f;
    r.back_value  = b;
    r.count       = c;
    r.is_empty    = e;
    r.status      = s;
    return r;
  endfunction

  task automatic add_row(input mode_t m, input logic signed [DATA_W-1:0] v,
                         input logic [POS_W-1:0] p, input bit typed, input rsp_t want);
    dir_row_t row;
    row.word.mode     = m;
    row.word.value    = v;
    row.word.position = p;
    row.typed         = typed;
    row.want          = want;
    dir_tab.push_back(row);
  endtask

  // Random request word, biased toward growing or shrinking the queue.
  function automatic req_t rand_word(input bit filling);
    req_t        w;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 3) begin
      w.mode = MODE_NOP;
    end else if (pick < (filling ? 62 : 28)) begin
      w.mode = MODE_ENQ;
    end else if (pick < (filling ? 80 : 64)) begin
      w.mode = MODE_DEQ;
    end else begin
      w.mode = MODE_REM;
    end
    case ($urandom_range(9))
      0: w.value = MIN_VAL;
      1: w.value = MAX_VAL;
      2: w.value = '0;
      3: w.value = '1;
      default: w.value = $urandom;
    endcase
    // Mostly a position that is held, sometimes any position at all.
    if (mirror_cnt != 0 && $urandom_range(3) != 0) begin
      w.position = POS_W'($urandom_range(mirror_cnt - 1));
    end else begin
      w.position = POS_W'($urandom_range((1 << POS_W) - 1));
    end
    return w;
  endfunction

  // Offer one request word and record its expected response once it is taken.
  task automatic send_word(input req_t w, input bit typed, input rsp_t want);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predicted = predict_queue_op(w);
    pending_rsp.push_back(typed ? want : predicted);
    words_taken++;
  endtask

  // Response side: check each taken word and pick the next ready value.
  always @(posedge clk) begin : rsp_side
    rsp_t want;
    if (rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected response word: front %0d back %0d count %0d empty %0b st %0d",
                   rsp.front_value, rsp.back_value, rsp.count, rsp.is_empty, rsp.status);
        end
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.front_value !== want.front_value || rsp.back_value !== want.back_value ||
            rsp.count !== want.count || rsp.is_empty !== want.is_empty ||
            rsp.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("response mismatch: expected front %0d back %0d count %0d empty %0b st %0d",
                     want.front_value, want.back_value, want.count, want.is_empty,
                     want.status);
            $display("                   actual   front %0d back %0d count %0d empty %0b st %0d",
                     rsp.front_value, rsp.back_value, rsp.count, rsp.is_empty, rsp.status);
          end
        end
      end
    end
    rsp_ready <= !rst && !hold_rsp && ($urandom_range(99) >= recv_idle);
  end

  // Long receiver stall so the block fills up and holds off the request side.
  initial begin : rsp_hold_off
    wait (words_taken >= HOLD_AFTER);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph;
    int unsigned n;
    int unsigned run_left;
    bit          filling;

    // Directed words: empty, range and full cases, extremes and every operation.
    add_row(MODE_DEQ, '1, 4'd15, 1'b1, mk_rsp('0, '0, 5'd0, 1'b1, ST_EMPTY));
    add_row(MODE_REM, '1, 4'd15, 1'b1, mk_rsp('0, '0, 5'd0, 1'b1, ST_EMPTY));
    add_row(MODE_NOP, MAX_VAL, 4'd9, 1'b1, mk_rsp('0, '0, 5'd0, 1'b1, ST_OK));
    add_row(MODE_ENQ, MIN_VAL, 4'd15, 1'b1, mk_rsp(MIN_VAL, MIN_VAL, 5'd1, 1'b0, ST_OK));
    add_row(MODE_ENQ, MAX_VAL, 4'd0, 1'b1, mk_rsp(MIN_VAL, MAX_VAL, 5'd2, 1'b0, ST_OK));
    add_row(MODE_REM, '0, 4'd2, 1'b1, mk_rsp(MIN_VAL, MAX_VAL, 5'd2, 1'b0, ST_RANGE));
    add_row(MODE_REM, '1, 4'd15, 1'b1, mk_rsp(MIN_VAL, MAX_VAL, 5'd2, 1'b0, ST_RANGE));
    for (n = 0; n < DEPTH - 3; n++) begin
      add_row(MODE_ENQ, 32'h3C3C_0000 | n, POS_W'(n), 1'b0, '0);
    end
    add_row(MODE_ENQ, LAST_FILL, 4'd3, 1'b0, '0);
    add_row(MODE_ENQ, '0, 4'd0, 1'b1,
            mk_rsp(MIN_VAL, LAST_FILL, COUNT_W'(DEPTH), 1'b0, ST_FULL));
    add_row(MODE_REM, '0, 4'd15, 1'b0, '0);
    add_row(MODE_REM, '1, 4'd0, 1'b0, '0);
    add_row(MODE_REM, '0, 4'd7, 1'b0, '0);
    add_row(MODE_DEQ, MIN_VAL, 4'd5, 1'b0, '0);

    send_idle = 33;
    recv_idle = 53;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    filling  = 1'b1;
    run_left = 40;
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 33;
          recv_idle = 53;
        end
        1: begin
          send_idle = 53;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      // Hold the next word back until every expected response has come.
      if (pending_rsp.size() != 0) begin
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
      end
      if (ph == 0) begin
        foreach (dir_tab[k]) begin
          send_word(dir_tab[k].word, dir_tab[k].typed, dir_tab[k].want);
        end
      end
      // Random words in runs that alternately fill and drain the queue.
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        if (run_left == 0) begin
          filling  = !filling;
          run_left = $urandom_range(80, 30);
        end
        run_left--;
        send_word(rand_word(filling), 1'b0, '0);
      end
    end
    req_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
